// ----- sv/gbct_pkg.sv -----
`timescale 1ns / 1ps

package gbct_pkg;

  localparam int CoordW = 24;
  localparam int TolW   = 16;
  localparam int ShiftW = 5;
  localparam int GridW  = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoordW:0]   cidx_t;

  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } box_t;

  localparam logic [CfgIdxW-1:0] CFG_CELL_SHIFT = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TOLERANCE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GRID_X     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GRID_Y     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GRID_Z     = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE = 2'd1;
  localparam logic [1:0] STAT_CELL    = 2'd2;
  localparam logic [1:0] STAT_TABLE   = 2'd3;

endpackage

// ----- sv/gbct_hit.sv -----
`timescale 1ns / 1ps

module gbct_hit (
  input  gbct_pkg::box_t              probe_i,
  input  gbct_pkg::box_t              stored_i,
  input  logic [gbct_pkg::TolW-1:0]   tolerance_i,
  output logic                        hit_o
);
  import gbct_pkg::*;

  logic [2:0] near;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coord_t mx;
      coord_t mn;
      cidx_t  gap;
      mx = (probe_i.lo[c] > stored_i.lo[c]) ? probe_i.lo[c] : stored_i.lo[c];
      mn = (probe_i.hi[c] < stored_i.hi[c]) ? probe_i.hi[c] : stored_i.hi[c];
      gap = cidx_t'(mx) - cidx_t'(mn);
      near[c] = gap < $signed({{(CoordW+1-TolW){1'b0}}, tolerance_i});
    end
  end

  assign hit_o = &near;

endmodule

// ----- sv/grid_box_collision_table.sv -----
`timescale 1ns / 1ps

// channel  | direction | handshake               | payload
// in       | input     | in_valid_i / in_ready_o | action_i, box_min_*_i, box_max_*_i
// out      | output    | out_valid_o / out_ready_i | clear_o, status_o
// cfg      | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// after reset a clearing pass zeroes every entry of the cell fill memory
// an item past the bound checks reads the fill count of each covered cell; a check reads
// and compares each stored box of a nonempty cell in turn until a hit (an add walks its
// cells twice, box write between passes), all through one fill, slot and box memory port
// in_ready_o is low while an item is in work; one finished result waits in the
// output register while the next item is taken

module grid_box_collision_table #(
  parameter int GRID_DIM_MAX  = 16,
  parameter int CELL_CAPACITY = 8,
  parameter int MAX_BOXES     = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gbct_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [gbct_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  gbct_pkg::coord_t                  box_min_x_i,
  input  gbct_pkg::coord_t                  box_min_y_i,
  input  gbct_pkg::coord_t                  box_min_z_i,
  input  gbct_pkg::coord_t                  box_max_x_i,
  input  gbct_pkg::coord_t                  box_max_y_i,
  input  gbct_pkg::coord_t                  box_max_z_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              clear_o,
  output logic [1:0]                        status_o
);
  import gbct_pkg::*;

  localparam int NCells = GRID_DIM_MAX * GRID_DIM_MAX * GRID_DIM_MAX;
  localparam int IW  = $clog2(GRID_DIM_MAX);
  localparam int DW  = $clog2(GRID_DIM_MAX + 1);
  localparam int CAW = $clog2(NCells);
  localparam int SAW = $clog2(NCells * CELL_CAPACITY);
  localparam int FW  = $clog2(CELL_CAPACITY + 1);
  localparam int BW  = $clog2(MAX_BOXES);
  localparam int BCW = $clog2(MAX_BOXES + 1);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_IDX  = 4'd2;
  localparam logic [3:0] ST_DEC  = 4'd3;
  localparam logic [3:0] ST_ROW  = 4'd4;
  localparam logic [3:0] ST_CELL = 4'd5;
  localparam logic [3:0] ST_FRD  = 4'd6;
  localparam logic [3:0] ST_FCHK = 4'd7;
  localparam logic [3:0] ST_SRD  = 4'd8;
  localparam logic [3:0] ST_BRD  = 4'd9;
  localparam logic [3:0] ST_CMP  = 4'd10;
  localparam logic [3:0] ST_BWR  = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  localparam logic [1:0] PH_CHECK = 2'd0;
  localparam logic [1:0] PH_SCAN  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  logic [ShiftW-1:0] cell_shift_q;
  logic [TolW-1:0]   tolerance_q;
  logic [GridW-1:0]  grid_q [3];

  logic [3:0]     state_q, state_d;
  logic [1:0]     ph_q, ph_d;
  logic           action_q, action_d;
  box_t           box_q, box_d;
  cidx_t [2:0]    imin_q, imin_d, imax_q, imax_d;
  logic [IW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CAW-1:0] row_q, row_d, cell_q, cell_d, clr_q, clr_d;
  logic [FW-1:0]  fill_q, fill_d, s_q, s_d;
  logic           full_q, full_d;
  logic [BCW-1:0] count_q, count_d;
  logic           ovalid_q, ovalid_d, oclear_q, oclear_d, res_clear_q, res_clear_d;
  logic [1:0]     ostat_q, ostat_d, res_stat_q, res_stat_d;

  logic [DW-1:0]  dim [3];
  logic [FW-1:0]  fill_mem [NCells];
  logic [BW-1:0]  slot_mem [NCells * CELL_CAPACITY];
  box_t           box_mem  [MAX_BOXES];
  logic [FW-1:0]  fill_rd_q;
  logic [BW-1:0]  slot_rd_q;
  box_t           box_rd_q;

  logic           fill_we, slot_we, box_we, hit;
  logic [CAW-1:0] fill_wa;
  logic [FW-1:0]  fill_wd;
  logic [SAW-1:0] slot_addr;
  logic           last;
  logic [IW-1:0]  ni, nj, nk;
  logic           empty, outside;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (8'(grid_q[c]) > 8'(GRID_DIM_MAX)) begin
        dim[c] = DW'(GRID_DIM_MAX);
      end else begin
        dim[c] = DW'(grid_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_shift_q <= ShiftW'(11);
      tolerance_q  <= TolW'(179);
      grid_q[0]    <= GridW'(16);
      grid_q[1]    <= GridW'(16);
      grid_q[2]    <= GridW'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CELL_SHIFT: cell_shift_q <= cfg_data_i[ShiftW-1:0];
        CFG_TOLERANCE:  tolerance_q  <= cfg_data_i[TolW-1:0];
        CFG_GRID_X:     grid_q[0]    <= cfg_data_i[GridW-1:0];
        CFG_GRID_Y:     grid_q[1]    <= cfg_data_i[GridW-1:0];
        CFG_GRID_Z:     grid_q[2]    <= cfg_data_i[GridW-1:0];
        default: ;
      endcase
    end
  end

  gbct_hit u_hit (
    .probe_i     (box_q),
    .stored_i    (box_rd_q),
    .tolerance_i (tolerance_q),
    .hit_o       (hit)
  );

  always_comb begin
    empty   = 1'b0;
    outside = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (imin_q[c] > imax_q[c]) empty = 1'b1;
      if (imin_q[c] < 0 || imax_q[c] >= $signed((CoordW+1)'(dim[c]))) outside = 1'b1;
    end
    last = (k_q == imax_q[2][IW-1:0]) && (j_q == imax_q[1][IW-1:0]) &&
           (i_q == imax_q[0][IW-1:0]);
    ni = i_q;
    nj = j_q;
    nk = k_q + IW'(1);
    if (k_q == imax_q[2][IW-1:0]) begin
      nk = imin_q[2][IW-1:0];
      nj = j_q + IW'(1);
      if (j_q == imax_q[1][IW-1:0]) begin
        nj = imin_q[1][IW-1:0];
        ni = i_q + IW'(1);
      end
    end
  end

  assign slot_addr = SAW'(cell_q) * SAW'(CELL_CAPACITY) +
                     SAW'((ph_q == PH_WRITE) ? fill_rd_q : s_q);

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    action_d = action_q;
    box_d = box_q;
    imin_d = imin_q;
    imax_d = imax_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    row_d = row_q;
    cell_d = cell_q;
    clr_d = clr_q;
    fill_d = fill_q;
    s_d = s_q;
    full_d = full_q;
    count_d = count_q;
    res_clear_d = res_clear_q;
    res_stat_d = res_stat_q;
    ovalid_d = ovalid_q;
    oclear_d = oclear_q;
    ostat_d = ostat_q;
    fill_we = 1'b0;
    fill_wa = cell_q;
    fill_wd = fill_rd_q + FW'(1);
    slot_we = 1'b0;
    box_we = 1'b0;
    in_ready_o = 1'b0;

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (state_q)
      ST_CLR: begin
        fill_we = 1'b1;
        fill_wa = clr_q;
        fill_wd = '0;
        clr_d = clr_q + CAW'(1);
        if (clr_q == CAW'(NCells - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          action_d = action_i;
          box_d.lo[0] = box_min_x_i;
          box_d.lo[1] = box_min_y_i;
          box_d.lo[2] = box_min_z_i;
          box_d.hi[0] = box_max_x_i;
          box_d.hi[1] = box_max_y_i;
          box_d.hi[2] = box_max_z_i;
          state_d = ST_IDX;
        end
      end
      ST_IDX: begin
        for (int c = 0; c < 3; c++) begin
          imin_d[c] = (cidx_t'(box_q.lo[c]) >>> cell_shift_q) + cidx_t'(1);
          imax_d[c] = (cidx_t'(box_q.hi[c]) >>> cell_shift_q) + cidx_t'(1);
        end
        state_d = ST_DEC;
      end
      ST_DEC: begin
        i_d = imin_q[0][IW-1:0];
        j_d = imin_q[1][IW-1:0];
        k_d = imin_q[2][IW-1:0];
        full_d = 1'b0;
        ph_d = action_q ? PH_SCAN : PH_CHECK;
        state_d = ST_OUT;
        if (empty) begin
          res_clear_d = 1'b1;
          res_stat_d = STAT_OK;
        end else if (outside) begin
          res_clear_d = 1'b0;
          res_stat_d = STAT_OUTSIDE;
        end else if (action_q && count_q >= BCW'(MAX_BOXES)) begin
          res_clear_d = 1'b0;
          res_stat_d = STAT_TABLE;
        end else begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        row_d = CAW'(i_q) * CAW'(dim[1]) + CAW'(j_q);
        state_d = ST_CELL;
      end
      ST_CELL: begin
        cell_d = row_q * CAW'(dim[2]) + CAW'(k_q);
        state_d = ST_FRD;
      end
      ST_FRD: state_d = ST_FCHK;
      ST_SRD: state_d = ST_BRD;
      ST_BRD: state_d = ST_CMP;
      ST_BWR: begin
        box_we = 1'b1;
        state_d = ST_ROW;
      end
      ST_FCHK, ST_CMP: begin
        logic adv;
        adv = 1'b0;
        if (state_q == ST_FCHK) begin
          fill_d = fill_rd_q;
          s_d = '0;
          case (ph_q)
            PH_CHECK: begin
              if (fill_rd_q == '0) adv = 1'b1;
              else state_d = ST_SRD;
            end
            PH_SCAN: begin
              if (fill_rd_q >= FW'(CELL_CAPACITY)) full_d = 1'b1;
              adv = 1'b1;
            end
            default: begin
              fill_we = 1'b1;
              slot_we = 1'b1;
              adv = 1'b1;
            end
          endcase
        end else begin
          if (hit) begin
            res_clear_d = 1'b0;
            res_stat_d = STAT_OK;
            state_d = ST_OUT;
          end else if (s_q + FW'(1) < fill_q) begin
            s_d = s_q + FW'(1);
            state_d = ST_SRD;
          end else begin
            adv = 1'b1;
          end
        end
        if (adv) begin
          if (!last) begin
            i_d = ni;
            j_d = nj;
            k_d = nk;
            state_d = ST_ROW;
          end else begin
            state_d = ST_OUT;
            case (ph_q)
              PH_CHECK: begin
                res_clear_d = 1'b1;
                res_stat_d = STAT_OK;
              end
              PH_SCAN: begin
                if (full_q || full_d) begin
                  res_clear_d = 1'b0;
                  res_stat_d = STAT_CELL;
                end else begin
                  ph_d = PH_WRITE;
                  i_d = imin_q[0][IW-1:0];
                  j_d = imin_q[1][IW-1:0];
                  k_d = imin_q[2][IW-1:0];
                  state_d = ST_BWR;
                end
              end
              default: begin
                count_d = count_q + BCW'(1);
                res_clear_d = 1'b1;
                res_stat_d = STAT_OK;
              end
            endcase
          end
        end
      end
      ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oclear_d = res_clear_q;
          ostat_d = res_stat_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      clr_q    <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q <= ph_d;
    action_q <= action_d;
    box_q <= box_d;
    imin_q <= imin_d;
    imax_q <= imax_d;
    i_q <= i_d;
    j_q <= j_d;
    k_q <= k_d;
    row_q <= row_d;
    cell_q <= cell_d;
    fill_q <= fill_d;
    s_q <= s_d;
    full_q <= full_d;
    res_clear_q <= res_clear_d;
    res_stat_q <= res_stat_d;
    oclear_q <= oclear_d;
    ostat_q <= ostat_d;
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    fill_rd_q <= fill_mem[cell_q];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_addr] <= count_q[BW-1:0];
    slot_rd_q <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk_i) begin
    if (box_we) box_mem[count_q[BW-1:0]] <= box_q;
    box_rd_q <= box_mem[slot_rd_q];
  end

  assign out_valid_o = ovalid_q;
  assign clear_o     = oclear_q;
  assign status_o    = ostat_q;

endmodule

// ----- tb/tb_grid_box_collision_table.sv -----
`timescale 1ns / 1ps

module tb_grid_box_collision_table;
  import gbct_pkg::*;

  localparam int DimMax = 16;
  localparam int CellCap = 8;
  localparam int MaxBoxes = 1024;
  localparam int NumCells = DimMax * DimMax * DimMax;
  localparam longint CycleLimit = 20000000;

  typedef struct {
    logic       add;
    coord_t     lo [3];
    coord_t     hi [3];
  } box_req_t;

  typedef struct {
    logic       clear;
    logic [1:0] status;
  } verdict_t;

  class collision_scoreboard;
    int unsigned shift;
    int unsigned tol;
    int unsigned gdim [3];
    longint      box_lo [MaxBoxes][3];
    longint      box_hi [MaxBoxes][3];
    int unsigned slots [NumCells][CellCap];
    int unsigned fill [NumCells];
    int unsigned count;
    verdict_t    pending [$];
    int          errors;

    function new();
      shift = 11;
      tol = 179;
      gdim = '{16, 16, 16};
      count = 0;
      errors = 0;
      foreach (fill[i]) fill[i] = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
      case (idx)
        CFG_CELL_SHIFT: shift = val & 31;
        CFG_TOLERANCE:  tol = val & 16'hffff;
        CFG_GRID_X:     gdim[0] = val & 31;
        CFG_GRID_Y:     gdim[1] = val & 31;
        CFG_GRID_Z:     gdim[2] = val & 31;
        default: ;
      endcase
    endfunction

    function longint cell_of(longint v);
      if (v >= 0) return (v >>> shift) + 1;
      return -((-v - 1) >>> shift);
    endfunction

    function bit overlaps(longint lo [3], longint hi [3], int unsigned b);
      longint gap;
      for (int c = 0; c < 3; c++) begin
        gap = ((lo[c] > box_lo[b][c]) ? lo[c] : box_lo[b][c]) -
              ((hi[c] < box_hi[b][c]) ? hi[c] : box_hi[b][c]);
        if (gap >= longint'(tol)) return 0;
      end
      return 1;
    endfunction

    function void note_input(box_req_t r);
      longint lo [3], hi [3], imin [3], imax [3], dim [3];
      bit empty, outside;
      verdict_t v;
      int unsigned cell_no;
      empty = 0;
      outside = 0;
      v.clear = 1;
      v.status = STAT_OK;
      for (int c = 0; c < 3; c++) begin
        dim[c] = (gdim[c] > DimMax) ? DimMax : gdim[c];
        lo[c] = r.lo[c];
        hi[c] = r.hi[c];
        imin[c] = cell_of(lo[c]);
        imax[c] = cell_of(hi[c]);
        if (imin[c] > imax[c]) empty = 1;
      end
      if (!empty)
        for (int c = 0; c < 3; c++)
          if (imin[c] < 0 || imax[c] >= dim[c]) outside = 1;
      if (empty) begin
      end else if (outside) begin
        v.clear = 0;
        v.status = STAT_OUTSIDE;
      end else if (!r.add) begin
        for (longint i = imin[0]; i <= imax[0]; i++)
          for (longint j = imin[1]; j <= imax[1]; j++)
            for (longint k = imin[2]; k <= imax[2]; k++) begin
              cell_no = int'((i * dim[1] + j) * dim[2] + k);
              for (int s = 0; s < fill[cell_no]; s++)
                if (overlaps(lo, hi, slots[cell_no][s])) v.clear = 0;
            end
      end else if (count >= MaxBoxes) begin
        v.clear = 0;
        v.status = STAT_TABLE;
      end else begin
        for (longint i = imin[0]; i <= imax[0]; i++)
          for (longint j = imin[1]; j <= imax[1]; j++)
            for (longint k = imin[2]; k <= imax[2]; k++) begin
              cell_no = int'((i * dim[1] + j) * dim[2] + k);
              if (fill[cell_no] >= CellCap) v.status = STAT_CELL;
            end
        if (v.status != STAT_OK) begin
          v.clear = 0;
        end else begin
          box_lo[count] = lo;
          box_hi[count] = hi;
          for (longint i = imin[0]; i <= imax[0]; i++)
            for (longint j = imin[1]; j <= imax[1]; j++)
              for (longint k = imin[2]; k <= imax[2]; k++) begin
                cell_no = int'((i * dim[1] + j) * dim[2] + k);
                slots[cell_no][fill[cell_no]] = count;
                fill[cell_no]++;
              end
          count++;
        end
      end
      pending = {pending, v};
    endfunction

    function void check_result(logic clear, logic [1:0] status);
      verdict_t v;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result clear=%0d status=%0d", $time, clear, status);
        errors++;
        return;
      end
      v = pending.pop_front();
      if (clear !== v.clear) begin
        $display("%0t: clear expected %0d actual %0d", $time, v.clear, clear);
        errors++;
      end
      if (status !== v.status) begin
        $display("%0t: status expected %0d actual %0d", $time, v.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic action_i = 0;
  coord_t box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  coord_t box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic clear_o;
  logic [1:0] status_o;

  collision_scoreboard sb = new();
  longint cycles = 0;
  int stall_mode = 0;

  always #4 clk_i = ~clk_i;

  grid_box_collision_table DUT (.*);

  // receiver stall pattern and output checking
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (out_valid_o && out_ready_i) sb.check_result(clear_o, status_o);
    case (stall_mode)
      0: out_ready_i <= 1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= ((cycles % 7) < 2);
    endcase
    if ($urandom_range(0, 200) == 0) stall_mode <= $urandom_range(0, 2);
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_box(box_req_t r);
    in_valid_i <= 1;
    action_i <= r.add;
    box_min_x_i <= r.lo[0];
    box_min_y_i <= r.lo[1];
    box_min_z_i <= r.lo[2];
    box_max_x_i <= r.hi[0];
    box_max_y_i <= r.hi[1];
    box_max_z_i <= r.hi[2];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(r);
  endtask

  task automatic gap_maybe(ref int burst);
    if (burst > 0) begin
      burst--;
      return;
    end
    in_valid_i <= 0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
    burst = $urandom_range(0, 10);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic box_req_t mk(logic add, int x0, int y0, int z0, int x1, int y1, int z1);
    box_req_t r;
    r.add = add;
    r.lo = '{coord_t'(x0), coord_t'(y0), coord_t'(z0)};
    r.hi = '{coord_t'(x1), coord_t'(y1), coord_t'(z1)};
    return r;
  endfunction

  // small box mostly in grid, in raw units of the current cell size
  function automatic box_req_t rand_box(logic add);
    box_req_t r;
    int unsigned cs;
    int span, base, ext;
    cs = 1 << sb.shift;
    r.add = add;
    for (int c = 0; c < 3; c++) begin
      span = ((sb.gdim[c] > DimMax) ? DimMax : sb.gdim[c]) - 1;
      base = $urandom_range(0, (span > 0) ? span * cs - 1 : 0) - cs;
      ext = $urandom_range(0, 2 * cs);
      if (base + ext > 8388607) ext = 0;
      r.lo[c] = coord_t'(base);
      r.hi[c] = coord_t'(base + ext);
      if ($urandom_range(0, 30) == 0) r.lo[c] = coord_t'($urandom);
      if ($urandom_range(0, 30) == 0) r.hi[c] = coord_t'($urandom);
    end
    return r;
  endfunction

  task automatic random_phase(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      send_box(rand_box($urandom_range(0, 1)));
      gap_maybe(burst);
    end
    drain();
  endtask

  initial begin
    int burst;
    burst = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, empty, outside, collide, cell full
    send_box(mk(0, 0, 0, 0, 0, 0, 0));
    send_box(mk(1, 0, 0, 0, 100, 100, 100));
    send_box(mk(0, 200, 200, 200, 300, 300, 300));
    send_box(mk(0, 260, 0, 0, 400, 50, 50));
    send_box(mk(0, 279, 0, 0, 400, 50, 50));
    send_box(mk(0, 100, 100, 100, 0, 0, 0));
    send_box(mk(1, 5000, 0, 0, 0, 0, 0));
    send_box(mk(0, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_box(mk(1, -1, 0, 0, 10, 10, 10));
    send_box(mk(1, -2049, 0, 0, 10, 10, 10));
    send_box(mk(0, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send_box(mk(0, -8388608, 0, 0, -8388608, 0, 0));
    for (int i = 0; i < 9; i++) send_box(mk(1, 4096, 4096, 4096, 4100, 4100, 4100 + i));
    send_box(mk(0, 4096, 4096, 4096, 4100, 4100, 4100));
    drain();
    // extremes of the registers
    write_reg(CFG_TOLERANCE, 16'hffff);
    write_reg(CFG_GRID_X, 31);
    write_reg(CFG_GRID_Y, 0);
    write_reg(CFG_GRID_Z, 16);
    send_box(mk(0, 0, 0, 0, 10, 10, 10));
    send_box(mk(0, 0, 100, 0, 10, -300, 10));
    drain();
    write_reg(CFG_CELL_SHIFT, 0);
    write_reg(CFG_TOLERANCE, 0);
    write_reg(CFG_GRID_X, 1);
    write_reg(CFG_GRID_Y, 1);
    write_reg(CFG_GRID_Z, 1);
    send_box(mk(0, -1, -1, -1, -1, -1, -1));
    send_box(mk(1, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(CFG_CELL_SHIFT, 31);
    write_reg(CFG_GRID_X, 2);
    write_reg(CFG_GRID_Y, 2);
    write_reg(CFG_GRID_Z, 2);
    send_box(mk(1, -8388608, -5, 0, 8388607, 5, 7));
    drain();
    // random phases over several settings
    write_reg(CFG_CELL_SHIFT, 11);
    write_reg(CFG_TOLERANCE, 179);
    write_reg(CFG_GRID_X, 16);
    write_reg(CFG_GRID_Y, 16);
    write_reg(CFG_GRID_Z, 16);
    random_phase(250);
    write_reg(CFG_CELL_SHIFT, 8);
    write_reg(CFG_TOLERANCE, $urandom_range(0, 2000));
    write_reg(CFG_GRID_X, 4);
    write_reg(CFG_GRID_Y, 3);
    write_reg(CFG_GRID_Z, 5);
    random_phase(250);
    write_reg(CFG_CELL_SHIFT, 20);
    write_reg(CFG_TOLERANCE, $urandom);
    write_reg(CFG_GRID_X, 16);
    write_reg(CFG_GRID_Y, 16);
    write_reg(CFG_GRID_Z, 16);
    random_phase(200);
    // mostly adds at a fine cell size
    write_reg(CFG_CELL_SHIFT, 4);
    write_reg(CFG_TOLERANCE, 0);
    for (int i = 0; i < 150; i++) begin
      send_box(rand_box((i % 5) != 0));
      gap_maybe(burst);
    end
    drain();
    random_phase(40);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
